// ===== sv/pidsl_pkg.sv =====
package pidsl_pkg;

    localparam int WARMUP_DEFAULT = 5;

    localparam int ERR_W   = 16;
    localparam int TS_W    = 32;
    localparam int DRIVE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 31;
    localparam int EPS_W   = 15;
    localparam int SLEW_W  = 16;
    localparam int MAXO_W  = 15;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = 50;
    localparam int DIV_W   = 32;

    localparam int PP_W    = 32;
    localparam int ED_W    = 48;
    localparam int STEP_W  = 48;
    localparam int INT_W   = 32;
    localparam int PD_W    = 34;
    localparam int CLAMP_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ON_CROSS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTPUT     = 3'd7;

    localparam logic [MAXO_W-1:0] MAX_OUTPUT_RESET = 15'd127;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== sv/pid_controller_slew_limited.sv =====
// PID controller with anti-windup and output slew limit.
// Input items arrive on the s_axis channel: tdata holds error_sample in bits
// 15:0 and timestamp_ms in bits 47:16. Each accepted item produces exactly one
// drive value on the m_axis channel, in tdata bits 15:0.
// Gains, limits, slew rate and flags are written on the cfg channel, which is
// always ready; write registers only while no item is in flight.
// One item is worked on at a time. The five products go through one shared
// shift-and-add multiplier, and the derivative quotient through a restoring
// divider that runs beside the multiplier. The next item is accepted only
// after the previous result has been placed in the output register.
// A finished result waits in an output register; while the receiver stalls
// the block can still accept and process the next item, and holds that
// result in its final step until the output register frees up.
// Reset clears the history, the integral and the warm-up count, and sets all
// registers to their defaults. The first samples after reset drive zero.
module pid_controller_slew_limited #(
    parameter int WARMUP_SAMPLES = pidsl_pkg::WARMUP_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bits from lowest: error_sample [15:0], timestamp_ms [47:16].
    input  logic [pidsl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Bits from lowest: drive [15:0].
    output logic [pidsl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidsl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pidsl_pkg::*;

    localparam int WarmW = $clog2(WARMUP_SAMPLES + 2);
    localparam logic [WarmW-1:0] WarmLimit = WarmW'(WARMUP_SAMPLES);
    localparam logic [WarmW-1:0] WarmSat   = WarmW'(WARMUP_SAMPLES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_DIVW  = 10'b0000000100,
        S_INT1  = 10'b0000001000,
        S_INT2  = 10'b0000010000,
        S_OUTQ  = 10'b0000100000,
        S_SLEW1 = 10'b0001000000,
        S_SLEW2 = 10'b0010000000,
        S_CLAMP = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        OP_D,
        OP_P,
        OP_E,
        OP_S,
        OP_I
    } op_t;

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [EPS_W-1:0]         eps_reg;
    logic [SLEW_W-1:0]        slew_reg;
    logic                     zoc_reg;
    logic [MAXO_W-1:0]        maxo_reg;

    // Control and controller state.
    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic                     issue_reg, issue_next;
    logic                     out_valid_reg;
    logic                     out_load;
    logic signed [ERR_W-1:0]  prev_err_reg, prev_err_next;
    logic [TS_W-1:0]          prev_time_reg, prev_time_next;
    logic signed [INT_W-1:0]  integ_reg, integ_next;
    logic signed [DRIVE_W-1:0] prev_drive_reg, prev_drive_next;
    logic [WarmW-1:0]         warm_reg, warm_next;

    // Working values of the current item.
    logic signed [ERR_W-1:0]   e_reg, e_next;
    logic [TS_W-1:0]           dt_reg, dt_next;
    logic signed [ERR_W:0]     de_reg, de_next;
    logic                      cross_reg, cross_next;
    logic                      dtz_reg, dtz_next;
    logic                      qneg_reg, qneg_next;
    logic signed [PP_W-1:0]    pp_reg, pp_next;
    logic signed [ED_W-1:0]    ed_reg, ed_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [PD_W-1:0]    pd_reg, pd_next;
    logic signed [MUL_P_W-1:0] cand_reg, cand_next;
    logic signed [MUL_P_W-1:0] outq_reg, outq_next;
    logic signed [MUL_P_W-1:0] diff_reg, diff_next;
    logic signed [MUL_P_W-1:0] newq_reg, newq_next;
    logic signed [CLAMP_W-1:0] clamp_reg, clamp_next;
    logic [DRIVE_W-1:0]        out_data_reg, out_data_next;

    // Arithmetic units: the shared multiplier and the divider.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_start;
    logic signed [MUL_P_W-1:0] mul_prod;
    unit_stat_t                mul_stat;
    logic                      div_start;
    logic [DIV_W-1:0]          div_num;
    logic [DIV_W-1:0]          div_quo;
    unit_stat_t                div_stat;

    // Combinational helpers.
    logic signed [ERR_W-1:0]   err_in;
    logic [TS_W-1:0]           ts_in;
    logic                      accept;
    logic                      warm;
    logic signed [DIV_W:0]     q_full;
    logic signed [PD_W-1:0]    lim_pd;
    logic                      pd_small;
    logic [ERR_W-1:0]          emag;
    logic signed [INT_W-1:0]   base_int;
    logic signed [MUL_P_W-1:0] lim_int;
    logic signed [MUL_P_W-1:0] int_clamped;
    logic signed [MUL_P_W-1:0] m_q8;
    logic signed [MUL_P_W-1:0] base_q8;
    logic signed [MUL_P_W-1:0] step_w;
    logic signed [MUL_P_W-1:0] out_clamped;
    logic                      cneg;
    logic [CLAMP_W-1:0]        cmag;
    logic [DRIVE_W-1:0]        dmag;
    logic [DRIVE_W-1:0]        drive_val;

    assign err_in = s_axis_tdata[ERR_W-1:0];
    assign ts_in  = s_axis_tdata[ERR_W +: TS_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign warm = (warm_reg < WarmLimit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            limit_reg  <= '0;
            eps_reg    <= '0;
            slew_reg   <= '0;
            zoc_reg    <= 1'b0;
            maxo_reg   <= MAX_OUTPUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN_P:         gain_p_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         gain_i_reg <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         gain_d_reg <= cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_EPSILON:        eps_reg    <= cfg_data[EPS_W-1:0];
                CFG_SLEW_RATE:      slew_reg   <= cfg_data[SLEW_W-1:0];
                CFG_ZERO_ON_CROSS:  zoc_reg    <= cfg_data[0];
                CFG_MAX_OUTPUT:     maxo_reg   <= cfg_data[MAXO_W-1:0];
                default:            ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (op_reg)
            OP_D:
            begin
                mul_a = MUL_A_W'(gain_d_reg);
                mul_b = MUL_B_W'(de_reg);
            end
            OP_P:
            begin
                mul_a = MUL_A_W'(gain_p_reg);
                mul_b = MUL_B_W'(e_reg);
            end
            OP_E:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            OP_S:
            begin
                mul_a = $signed({1'b0, slew_reg});
                mul_b = $signed({1'b0, dt_reg});
            end
            OP_I:
            begin
                mul_a = MUL_A_W'(gain_i_reg);
                mul_b = MUL_B_W'(integ_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (state_reg == S_MUL) && issue_reg;
    assign div_start = (state_reg == S_MUL) && mul_stat.done && (op_reg == OP_D);
    assign div_num   = mul_prod[MUL_P_W-1] ? (DIV_W'(0) - mul_prod[DIV_W-1:0])
                                           : mul_prod[DIV_W-1:0];

    pidsl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    pidsl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dt_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Datapath terms used by the steps of the sequencer.
    always_comb
    begin
        if (dtz_reg)
        begin
            q_full = '0;
        end
        else if (qneg_reg)
        begin
            q_full = -$signed({1'b0, div_quo});
        end
        else
        begin
            q_full = $signed({1'b0, div_quo});
        end

        lim_pd   = $signed(PD_W'({maxo_reg, 8'd0}));
        pd_small = (pd_reg < lim_pd) && (pd_reg > -lim_pd);
        emag     = e_reg[ERR_W-1] ? (ERR_W'(0) - e_reg) : e_reg;
        base_int = (zoc_reg && cross_reg) ? '0 : integ_reg;

        lim_int = $signed(MUL_P_W'(limit_reg));
        if (cand_reg > lim_int)
        begin
            int_clamped = lim_int;
        end
        else if (cand_reg < -lim_int)
        begin
            int_clamped = -lim_int;
        end
        else
        begin
            int_clamped = cand_reg;
        end

        m_q8    = $signed(MUL_P_W'({maxo_reg, 8'd0}));
        base_q8 = MUL_P_W'($signed({prev_drive_reg, 8'd0}));
        step_w  = $signed(MUL_P_W'(step_reg));

        if (newq_reg > m_q8)
        begin
            out_clamped = m_q8;
        end
        else if (newq_reg < -m_q8)
        begin
            out_clamped = -m_q8;
        end
        else
        begin
            out_clamped = newq_reg;
        end

        // Divide by 256 rounding toward zero.
        cneg      = clamp_reg[CLAMP_W-1];
        cmag      = cneg ? (CLAMP_W'(0) - clamp_reg) : clamp_reg;
        dmag      = DRIVE_W'(cmag[CLAMP_W-1:8]);
        drive_val = cneg ? (DRIVE_W'(0) - dmag) : dmag;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        issue_next      = issue_reg;
        out_load        = 1'b0;
        prev_err_next   = prev_err_reg;
        prev_time_next  = prev_time_reg;
        integ_next      = integ_reg;
        prev_drive_next = prev_drive_reg;
        warm_next       = warm_reg;
        e_next          = e_reg;
        dt_next         = dt_reg;
        de_next         = de_reg;
        cross_next      = cross_reg;
        dtz_next        = dtz_reg;
        qneg_next       = qneg_reg;
        pp_next         = pp_reg;
        ed_next         = ed_reg;
        step_next       = step_reg;
        pd_next         = pd_reg;
        cand_next       = cand_reg;
        outq_next       = outq_reg;
        diff_next       = diff_reg;
        newq_next       = newq_reg;
        clamp_next      = clamp_reg;
        out_data_next   = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    e_next         = err_in;
                    dt_next        = ts_in - prev_time_reg;
                    dtz_next       = (ts_in == prev_time_reg);
                    de_next        = (ERR_W + 1)'(err_in) - (ERR_W + 1)'(prev_err_reg);
                    cross_next     = (err_in[ERR_W-1] != prev_err_reg[ERR_W-1])
                                     || ((err_in == '0) != (prev_err_reg == '0));
                    prev_err_next  = err_in;
                    prev_time_next = ts_in;
                    op_next        = OP_D;
                    issue_next     = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                if (issue_reg)
                begin
                    issue_next = 1'b0;
                end
                if (mul_stat.done)
                begin
                    case (op_reg)
                        OP_D:
                        begin
                            qneg_next  = mul_prod[MUL_P_W-1];
                            op_next    = OP_P;
                            issue_next = 1'b1;
                        end
                        OP_P:
                        begin
                            pp_next    = mul_prod[PP_W-1:0];
                            op_next    = OP_E;
                            issue_next = 1'b1;
                        end
                        OP_E:
                        begin
                            ed_next    = mul_prod[ED_W-1:0];
                            op_next    = OP_S;
                            issue_next = 1'b1;
                        end
                        OP_S:
                        begin
                            step_next  = mul_prod[STEP_W-1:0];
                            state_next = S_DIVW;
                        end
                        OP_I:
                        begin
                            state_next = S_OUTQ;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIVW:
            begin
                if (!div_stat.busy)
                begin
                    pd_next    = PD_W'(pp_reg) + PD_W'(q_full);
                    state_next = S_INT1;
                end
            end
            S_INT1:
            begin
                if (!pd_small)
                begin
                    cand_next = MUL_P_W'(base_int);
                end
                else if (emag > {1'b0, eps_reg})
                begin
                    cand_next = MUL_P_W'(base_int) + MUL_P_W'(ed_reg);
                end
                else
                begin
                    cand_next = '0;
                end
                state_next = S_INT2;
            end
            S_INT2:
            begin
                integ_next = int_clamped[INT_W-1:0];
                op_next    = OP_I;
                issue_next = 1'b1;
                state_next = S_MUL;
            end
            S_OUTQ:
            begin
                outq_next  = MUL_P_W'(pd_reg) + mul_prod;
                state_next = S_SLEW1;
            end
            S_SLEW1:
            begin
                diff_next  = outq_reg - base_q8;
                state_next = S_SLEW2;
            end
            S_SLEW2:
            begin
                if (!dtz_reg && ((diff_reg > step_w) || (diff_reg < -step_w)))
                begin
                    newq_next = diff_reg[MUL_P_W-1] ? (base_q8 - step_w)
                                                    : (base_q8 + step_w);
                end
                else
                begin
                    newq_next = outq_reg;
                end
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                clamp_next = out_clamped[CLAMP_W-1:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    if (warm)
                    begin
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_data_next   = drive_val;
                        prev_drive_next = drive_val;
                    end
                    if (warm_reg != WarmSat)
                    begin
                        warm_next = warm_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_D;
            issue_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            prev_time_reg  <= '0;
            integ_reg      <= '0;
            prev_drive_reg <= '0;
            warm_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            issue_reg      <= issue_next;
            prev_err_reg   <= prev_err_next;
            prev_time_reg  <= prev_time_next;
            integ_reg      <= integ_next;
            prev_drive_reg <= prev_drive_next;
            warm_reg       <= warm_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        dt_reg       <= dt_next;
        de_reg       <= de_next;
        cross_reg    <= cross_next;
        dtz_reg      <= dtz_next;
        qneg_reg     <= qneg_next;
        pp_reg       <= pp_next;
        ed_reg       <= ed_next;
        step_reg     <= step_next;
        pd_reg       <= pd_next;
        cand_reg     <= cand_next;
        outq_reg     <= outq_next;
        diff_reg     <= diff_next;
        newq_reg     <= newq_next;
        clamp_reg    <= clamp_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== sv/pidsl_mul.sv =====
module pidsl_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [pidsl_pkg::MUL_A_W-1:0] a,
    input  logic signed [pidsl_pkg::MUL_B_W-1:0] b,
    output pidsl_pkg::unit_stat_t                stat,
    output logic signed [pidsl_pkg::MUL_P_W-1:0] prod
);
    import pidsl_pkg::*;

    localparam int CntW = $clog2(MUL_A_W);
    localparam logic [CntW-1:0] LastBit = CntW'(MUL_A_W - 1);

    logic [MUL_A_W-1:0]        a_reg;
    logic signed [MUL_P_W-1:0] b_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic signed [MUL_P_W-1:0] acc_next;
    logic signed [MUL_P_W-1:0] addend;
    logic [CntW-1:0]           cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    // The top bit of the multiplier carries negative weight.
    always_comb
    begin
        addend = a_reg[0] ? b_reg : '0;
        if (cnt_reg == LastBit)
        begin
            acc_next = acc_reg - addend;
        end
        else
        begin
            acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LastBit)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= MUL_P_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg >> 1;
            b_reg   <= b_reg <<< 1;
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// ===== sv/pidsl_div.sv =====
module pidsl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pidsl_pkg::DIV_W-1:0]   num,
    input  logic [pidsl_pkg::DIV_W-1:0]   den,
    output pidsl_pkg::unit_stat_t         stat,
    output logic [pidsl_pkg::DIV_W-1:0]   quo
);
    import pidsl_pkg::*;

    localparam int CntW = $clog2(DIV_W);
    localparam logic [CntW-1:0] LastStep = CntW'(DIV_W - 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;
    logic             fits;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // Restoring division, one quotient bit per cycle, most significant first.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        trial    = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LastStep)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign stat = '{busy: busy_reg, done: done_reg};

endmodule

// ===== sv/pidsl_check.sv =====
module pidsl_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pidsl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pidsl_pkg::*;

    localparam logic [OUT_DATA_W-1:0] MostNegative = {1'b1, {(OUT_DATA_W - 1){1'b0}}};

    // Only one item is in flight, so the input closes right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // A new result appears exactly when the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result presented while the sequencer is busy");

    // The drive is clamped symmetrically and never reaches the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != MostNegative))
        else $error("drive outside the symmetric range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind pid_controller_slew_limited pidsl_check u_pidsl_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;

    import pidsl_pkg::*;

    localparam int QUIET_LIMIT       = 5000;
    localparam int HOLD_CYCLES       = 600;
    localparam int DRAIN_CYCLES      = 150;
    localparam int SETTINGS_PER_MODE = 6;
    localparam int ITEMS_PER_SETTING = 50;

    typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      value;
        logic signed [ERR_W-1:0]    err;
        logic [TS_W-1:0]            ts;
        logic                       has_drive;
        logic signed [DRIVE_W-1:0]  drive;
    } dir_row_t;

    localparam int DIR_N = 47;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_WRITE, CFG_GAIN_P,         32'h0000_7FFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_I,         32'hFFFF_8000, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_D,         32'h0000_7FFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_INTEGRAL_LIMIT, 32'h7FFF_FFFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_EPSILON,        32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_SLEW_RATE,      32'h0000_FFFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_ZERO_ON_CROSS,  32'd1,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAX_OUTPUT,     32'h0000_7FFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sh7FFF, 32'd1,         1'b1, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sh8000, 32'd2,         1'b1, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd0,    32'd2,         1'b1, 16'sd0},
        '{ROW_ITEM,  '0, '0, -16'sd1,   32'd3,         1'b1, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd1,    32'd0,         1'b1, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd100,  32'd5,         1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sh8000, 32'd5,         1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_P,         32'd256,       16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_I,         32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_D,         32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_SLEW_RATE,      32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_MAX_OUTPUT,     32'd127,       16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_ZERO_ON_CROSS,  32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd100,  32'd5,         1'b1, 16'sd100},
        '{ROW_ITEM,  '0, '0, 16'sh7FFF, 32'd5,         1'b1, 16'sd127},
        '{ROW_ITEM,  '0, '0, 16'sh8000, 32'd5,         1'b1, -16'sd127},
        '{ROW_ITEM,  '0, '0, 16'sd50,   32'd6,         1'b1, -16'sd127},
        '{ROW_WRITE, CFG_MAX_OUTPUT,     32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd1000, 32'd7,         1'b1, 16'sd0},
        '{ROW_ITEM,  '0, '0, -16'sd5,   32'd7,         1'b1, 16'sd0},
        '{ROW_WRITE, CFG_MAX_OUTPUT,     32'd127,       16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_SLEW_RATE,      32'd256,       16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_EPSILON,        32'h0000_7FFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_I,         32'd256,       16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_INTEGRAL_LIMIT, 32'd0,         16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd0,    32'd8,         1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd20,   32'd18,        1'b0, 16'sd0},
        '{ROW_WRITE, CFG_EPSILON,        32'd10,        16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_INTEGRAL_LIMIT, 32'd1000,      16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_ZERO_ON_CROSS,  32'hFFFF_FFFF, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_D,         32'hFFFF_8000, 16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_WRITE, CFG_GAIN_P,         32'd64,        16'sd0,     32'd0, 1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd5,    32'd20,        1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, -16'sd5,   32'd21,        1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd0,    32'd21,        1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, -16'sd300, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd300,  32'd10,        1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sd12,   32'd30,        1'b0, 16'sd0},
        '{ROW_ITEM,  '0, '0, 16'sh7FFF, 32'h8000_0000, 1'b0, 16'sd0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    pid_controller_slew_limited dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Register copies and controller history used for prediction.
    longint kp, ki, kd, int_limit, err_band, slew_q8, out_max;
    bit     clear_on_cross;
    longint hist_err, integ, hist_drive;
    logic [TS_W-1:0] hist_ts;
    int     warm_count;

    logic signed [DRIVE_W-1:0] expected_drive [$];

    int tx_idle_pct = 15;
    int rx_idle_pct = 57;
    logic hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;

    int fail_count = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int drives_checked = 0;
    int settings_used = 0;
    logic signed [DRIVE_W-1:0] want_drive;

    function automatic int sign_of(longint v);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_sym(longint v, longint bound);
        if (v > bound)
            return bound;
        if (v < -bound)
            return -bound;
        return v;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] pid_step(logic signed [ERR_W-1:0] err,
                                                           logic [TS_W-1:0] ts);
        longint e, dt, last_e, pd, out_q8, new_q8, base_q8, step_q8, diff, drv;
        logic [TS_W-1:0] dt_raw;
        e = longint'(err);
        dt_raw = ts - hist_ts;
        dt = longint'(dt_raw);
        last_e = hist_err;
        hist_ts = ts;
        hist_err = e;
        pd = kp * e;
        if (dt != 0)
            pd += (kd * (e - last_e)) / dt;
        if (clear_on_cross && sign_of(e) != sign_of(last_e))
            integ = 0;
        if (magnitude(pd) < out_max * 256)
            integ = (magnitude(e) > err_band) ? integ + e * dt : 0;
        integ = clamp_sym(integ, int_limit);
        out_q8 = pd + ki * integ;
        if (warm_count <= WARMUP_DEFAULT)
            warm_count++;
        if (warm_count <= WARMUP_DEFAULT)
            return '0;
        base_q8 = hist_drive * 256;
        new_q8 = out_q8;
        if (dt != 0)
        begin
            step_q8 = slew_q8 * dt;
            diff = out_q8 - base_q8;
            if (magnitude(diff) > step_q8)
                new_q8 = base_q8 + sign_of(diff) * step_q8;
        end
        new_q8 = clamp_sym(new_q8, out_max * 256);
        drv = new_q8 / 256;
        hist_drive = drv;
        return drv[DRIVE_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_P:         kp = longint'($signed(value[GAIN_W-1:0]));
            CFG_GAIN_I:         ki = longint'($signed(value[GAIN_W-1:0]));
            CFG_GAIN_D:         kd = longint'($signed(value[GAIN_W-1:0]));
            CFG_INTEGRAL_LIMIT: int_limit = longint'(value[LIMIT_W-1:0]);
            CFG_EPSILON:        err_band = longint'(value[EPS_W-1:0]);
            CFG_SLEW_RATE:      slew_q8 = longint'(value[SLEW_W-1:0]);
            CFG_ZERO_ON_CROSS:  clear_on_cross = value[0];
            CFG_MAX_OUTPUT:     out_max = longint'(value[MAXO_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_item(logic signed [ERR_W-1:0] err, logic [TS_W-1:0] ts,
                             logic has_drive, logic signed [DRIVE_W-1:0] drive);
        logic signed [DRIVE_W-1:0] predicted;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 110)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ts, err};
        do @(posedge clk); while (!s_axis_tready);
        predicted = pid_step(err, ts);
        expected_drive.push_back(has_drive ? drive : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_drive.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] setting_value(logic [CFG_IDX_W-1:0] idx);
        int pick;
        int w;
        logic [CFG_DATA_W-1:0] v, mask, noise;
        pick = $urandom_range(7);
        noise = $urandom;
        case (idx)
            CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D:
            begin
                w = GAIN_W;
                v = (pick == 0) ? 32'h8000 : (pick == 1) ? 32'h7FFF :
                    int'($urandom_range(0, 2048)) - 1024;
            end
            CFG_INTEGRAL_LIMIT:
            begin
                w = LIMIT_W;
                v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h7FFF_FFFF :
                    $urandom_range(0, 500000);
            end
            CFG_EPSILON:
            begin
                w = EPS_W;
                v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h7FFF : $urandom_range(0, 300);
            end
            CFG_SLEW_RATE:
            begin
                w = SLEW_W;
                v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF : $urandom_range(1, 8192);
            end
            CFG_ZERO_ON_CROSS:
            begin
                w = 1;
                v = $urandom_range(1);
            end
            default:
            begin
                w = MAXO_W;
                v = (pick == 0) ? 32'd1 : (pick == 1) ? 32'h7FFF : $urandom_range(1, 2000);
            end
        endcase
        mask = (32'h1 << w) - 1;
        return (noise & ~mask) | (v & mask);
    endfunction

    task automatic pick_settings();
        for (int r = CFG_GAIN_P; r <= CFG_MAX_OUTPUT; r++)
            write_reg(r[CFG_IDX_W-1:0], setting_value(r[CFG_IDX_W-1:0]));
        settings_used++;
    endtask

    function automatic logic signed [ERR_W-1:0] random_error(logic signed [ERR_W-1:0] prior);
        int span;
        span = (err_band > 32717) ? 32767 : int'(err_band) + 50;
        case ($urandom_range(9))
            0, 1, 2, 3: return ERR_W'(int'($urandom_range(0, 2 * span)) - span);
            4, 5:       return ERR_W'($urandom);
            6:
            begin
                case ($urandom_range(4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sd0;
                    3:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            7:          return -prior;
            default:    return ERR_W'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic [TS_W-1:0] random_step();
        case ($urandom_range(9))
            6:       return '0;
            7:       return $urandom_range(21, 1000);
            8:       return $urandom;
            9:       return 32'd1;
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $display("%0t: drive %0d arrived with nothing expected",
                             $time, $signed(m_axis_tdata));
                    fail_count++;
                end
                else
                begin
                    want_drive = expected_drive.pop_front();
                    drives_checked++;
                    if ($signed(m_axis_tdata) !== want_drive)
                    begin
                        $display("%0t: drive mismatch, expected %0d, got %0d",
                                 $time, want_drive, $signed(m_axis_tdata));
                        fail_count++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d drives outstanding",
                         $time, QUIET_LIMIT, expected_drive.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] last_err;
        logic [TS_W-1:0] ts_now;
        int directed_items;
        kp = 0;
        ki = 0;
        kd = 0;
        int_limit = 0;
        err_band = 0;
        slew_q8 = 0;
        clear_on_cross = 1'b0;
        out_max = longint'(MAX_OUTPUT_RESET);
        hist_err = 0;
        integ = 0;
        hist_drive = 0;
        hist_ts = '0;
        warm_count = 0;
        last_err = '0;
        ts_now = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 15;
        rx_idle_pct = 57;
        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value);
            end
            else
            begin
                send_item(DIR_ROWS[i].err, DIR_ROWS[i].ts, DIR_ROWS[i].has_drive,
                          DIR_ROWS[i].drive);
                last_err = DIR_ROWS[i].err;
                ts_now = DIR_ROWS[i].ts;
            end
        end
        directed_items = items_sent;

        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = (mode == 0) ? 15 : (mode == 1) ? 57 : 0;
            rx_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 15 : 0;
            for (int s = 0; s < SETTINGS_PER_MODE; s++)
            begin
                drain_results();
                if (mode == 2 && s == 0)
                    hold_req <= 1'b1;
                pick_settings();
                for (int k = 0; k < ITEMS_PER_SETTING; k++)
                begin
                    err = random_error(last_err);
                    ts_now = ts_now + random_step();
                    send_item(err, ts_now, 1'b0, '0);
                    last_err = err;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_drive.size() != 0)
        begin
            $display("%0t: %0d drives never arrived", $time, expected_drive.size());
            fail_count++;
        end

        $display("Ran %0d directed and %0d random samples over %0d random register sets,",
                 directed_items, items_sent - directed_items, settings_used);
        $display("with warm-up, zero and wrapped time steps and stalls; %0d drives checked.",
                 drives_checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/pidsl_pkg.sv
sv/pidsl_mul.sv
sv/pidsl_div.sv
sv/pid_controller_slew_limited.sv
sv/pidsl_check.sv
tb/sv/tb_top.sv
